/* sv/rgbls_pkg.sv */
// ============================================================================
// rgbls_pkg
// Shared types, constants and pixel arithmetic for the RGB565 region luma
// statistics block.
// ============================================================================
package rgbls_pkg;

  // Frame geometry limits and the widths that follow from them.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int XW         = $clog2(MAX_WIDTH);

  // Fixed field widths.
  localparam int DIM_W     = 11;
  localparam int LEVEL_W   = 8;
  localparam int LUMA_W    = 8;
  localparam int ROW_W     = 10;
  localparam int SEEN_W    = 21;
  localparam int TOTAL_W   = 28;
  localparam int SUM_W     = 27;
  localparam int CNT_W     = 20;
  localparam int EDGE_W    = 21;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] DIM_FLOOR    = 11'd2;
  localparam logic [ROW_W-1:0] ROW_LIMIT    = '1;

  // Register reset values.
  localparam logic [DIM_W-1:0]   WIDTH_RESET     = 11'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET    = 11'd480;
  localparam logic [LEVEL_W-1:0] SATURATE_RESET  = 8'd245;
  localparam logic [LEVEL_W-1:0] HIGHLIGHT_RESET = 8'd230;
  localparam logic [LEVEL_W-1:0] EDGE_RESET      = 8'd22;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATE_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHLIGHT_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_STEP       = 3'd4;

  // Input transaction.
  typedef struct packed {
    logic [15:0] pixel_word;
    logic        end_of_frame;
  } pix_t;

  // Result transaction.
  typedef struct packed {
    logic              status;
    logic              region;
    logic [SUM_W-1:0]  luma_sum;
    logic [CNT_W-1:0]  pixel_count;
    logic [CNT_W-1:0]  saturated_count;
    logic [CNT_W-1:0]  highlight_count;
    logic [EDGE_W-1:0] edge_count;
    logic [EDGE_W-1:0] edge_test_count;
    logic              last;
  } res_t;

  // Running totals of one half of the frame.
  typedef struct packed {
    logic [TOTAL_W-1:0] luma;
    logic [CNT_W-1:0]   pixels;
    logic [CNT_W-1:0]   saturated;
    logic [CNT_W-1:0]   highlighted;
    logic [EDGE_W-1:0]  edges;
    logic [EDGE_W-1:0]  tests;
  } stats_t;

  // Thresholds used by the statistics stage.
  typedef struct packed {
    logic [LEVEL_W-1:0] saturate;
    logic [LEVEL_W-1:0] highlight;
    logic [LEVEL_W-1:0] edge_step;
  } levels_t;

  // Pixel as it enters the statistics stage.
  typedef struct packed {
    logic [XW-1:0]     x;
    logic [LUMA_W-1:0] luma;
    logic [LUMA_W-1:0] row_luma;
    logic              region;
    logic              h_test;
    logic              v_test;
    logic              eof;
    logic              mismatch;
  } px_t;

  // Widen a 5-bit channel to 0..255 as c*255/31, truncated.
  // c*255/31 = 8c + floor(7c/31); the second term steps at fixed codes.
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [2:0] f;
    f = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
      + 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
    return {c, 3'b000} + 8'(f);
  endfunction

  // Widen a 6-bit channel to 0..255 as c*255/63, truncated: 4c + floor(c/21).
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [1:0] f;
    f = 2'(c >= 6'd21) + 2'(c >= 6'd42) + 2'(c >= 6'd63);
    return {c, 2'b00} + 8'(f);
  endfunction

  // Weighted luma of widened channels.
  function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [15:0] s;
    s = 16'd77 * 16'(r) + 16'd150 * 16'(g) + 16'd29 * 16'(b);
    return s[15:8];
  endfunction

endpackage

/* sv/rgbls_row_ram.sv */
// ============================================================================
// rgbls_row_ram
// One-row luma store: one write port, one read port, registered read data.
// A read and a write to the same entry at one edge return the new data.
// ============================================================================
module rgbls_row_ram (
  input  logic                            clk,
  input  logic                            rd_en,
  input  logic [rgbls_pkg::XW-1:0]        rd_addr,
  output logic [rgbls_pkg::LUMA_W-1:0]    rd_data,
  input  logic                            wr_en,
  input  logic [rgbls_pkg::XW-1:0]        wr_addr,
  input  logic [rgbls_pkg::LUMA_W-1:0]    wr_data
);

  logic [rgbls_pkg::LUMA_W-1:0] mem [rgbls_pkg::MAX_WIDTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with write-through forwarding.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

/* sv/rgbls_accum.sv */
// ============================================================================
// rgbls_accum
// Per-half statistics: luma sum, pixel, saturated and highlight counts, and
// the horizontal and vertical edge tests. All counters saturate.
// ============================================================================
module rgbls_accum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  rgbls_pkg::px_t              px,
  input  rgbls_pkg::levels_t          levels,
  output rgbls_pkg::stats_t [1:0]     totals_final
);

  rgbls_pkg::stats_t [1:0]        stats;
  rgbls_pkg::stats_t              cur;
  rgbls_pkg::stats_t              upd;
  logic [rgbls_pkg::LUMA_W-1:0]   prior_luma;
  logic [rgbls_pkg::LUMA_W-1:0]   diff_h;
  logic [rgbls_pkg::LUMA_W-1:0]   diff_v;
  logic                           hit_h;
  logic                           hit_v;
  logic [1:0]                     tests_add;
  logic [1:0]                     edges_add;
  logic [rgbls_pkg::TOTAL_W:0]    luma_sum;
  logic [rgbls_pkg::EDGE_W:0]     tests_sum;
  logic [rgbls_pkg::EDGE_W:0]     edges_sum;

  // Edge tests against the previous pixel of the row and the row above.
  always_comb begin
    diff_h    = (px.luma >= prior_luma) ? px.luma - prior_luma : prior_luma - px.luma;
    diff_v    = (px.luma >= px.row_luma) ? px.luma - px.row_luma : px.row_luma - px.luma;
    hit_h     = px.h_test && (diff_h >= levels.edge_step);
    hit_v     = px.v_test && (diff_v >= levels.edge_step);
    tests_add = 2'(px.h_test) + 2'(px.v_test);
    edges_add = 2'(hit_h) + 2'(hit_v);
  end

  // Saturating update of the half that this pixel belongs to.
  always_comb begin
    cur       = stats[px.region];
    upd       = cur;
    luma_sum  = {1'b0, cur.luma} + (rgbls_pkg::TOTAL_W + 1)'(px.luma);
    tests_sum = {1'b0, cur.tests} + (rgbls_pkg::EDGE_W + 1)'(tests_add);
    edges_sum = {1'b0, cur.edges} + (rgbls_pkg::EDGE_W + 1)'(edges_add);
    upd.luma  = luma_sum[rgbls_pkg::TOTAL_W] ? '1 : luma_sum[rgbls_pkg::TOTAL_W-1:0];
    upd.tests = tests_sum[rgbls_pkg::EDGE_W] ? '1 : tests_sum[rgbls_pkg::EDGE_W-1:0];
    upd.edges = edges_sum[rgbls_pkg::EDGE_W] ? '1 : edges_sum[rgbls_pkg::EDGE_W-1:0];
    if (!(&cur.pixels)) begin
      upd.pixels = cur.pixels + 1'b1;
    end
    if ((px.luma >= levels.saturate) && !(&cur.saturated)) begin
      upd.saturated = cur.saturated + 1'b1;
    end
    if ((px.luma >= levels.highlight) && !(&cur.highlighted)) begin
      upd.highlighted = cur.highlighted + 1'b1;
    end
  end

  // Totals including the current pixel, for the end-of-frame snapshot.
  always_comb begin
    totals_final = stats;
    totals_final[px.region] = upd;
  end

  // Totals clear after every end of frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      stats      <= '0;
      prior_luma <= '0;
    end else if (take) begin
      prior_luma <= px.luma;
      if (px.eof) begin
        stats <= '0;
      end else begin
        stats[px.region] <= upd;
      end
    end
  end

endmodule

/* sv/rgbls_result_buf.sv */
// ============================================================================
// rgbls_result_buf
// Holds one frame's end snapshot and sends either the mismatch status or the
// two region results, left half first.
// ============================================================================
module rgbls_result_buf (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        load_mismatch,
  input  rgbls_pkg::stats_t [1:0]     load_stats,
  output logic                        busy,
  output logic                        res_valid,
  input  logic                        res_stall,
  output rgbls_pkg::res_t             res
);

  rgbls_pkg::stats_t [1:0] snap;
  rgbls_pkg::stats_t       sel;
  logic                    idx;
  logic                    mismatch;
  logic                    done;

  assign res_valid = busy;
  assign done      = busy && !res_stall;

  // Result fields from the held snapshot.
  always_comb begin
    sel = snap[idx];
    res = '0;
    if (mismatch) begin
      res.status = 1'b1;
      res.last   = 1'b1;
    end else begin
      res.region          = idx;
      res.luma_sum        = sel.luma[rgbls_pkg::SUM_W-1:0];
      res.pixel_count     = sel.pixels;
      res.saturated_count = sel.saturated;
      res.highlight_count = sel.highlighted;
      res.edge_count      = sel.edges;
      res.edge_test_count = sel.tests;
      res.last            = idx;
    end
  end

  // Snapshot payload.
  always_ff @(posedge clk) begin
    if (load) begin
      snap     <= load_stats;
      mismatch <= load_mismatch;
    end
  end

  // Sequencing of the one or two results.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 1'b0;
    end else if (done) begin
      if (mismatch || idx) begin
        busy <= 1'b0;
      end else begin
        idx <= 1'b1;
      end
    end
  end

endmodule

/* sv/rgb565_split_region_luma_stats.sv */
// ============================================================================
// rgb565_split_region_luma_stats
// Region luma statistics over an RGB565 raster stream, split into left and
// right halves, with edge tests against a one-row luma store.
// ============================================================================
//
//   channel  direction  handshake              payload
//   pix      in         pix_valid / pix_stall  pixel_word, end_of_frame
//   res      out        res_valid / res_stall  status .. last
//   cfg      in         cfg_we                 cfg_index, cfg_data
//
// One pixel is accepted per cycle unless the input stalls. A pixel passes a
// widening stage (row store read), a luma stage and the statistics stage; a
// frame's results are then sent one per cycle unless res_stall holds them.
// Input stalls only while a frame's last pixel waits in the statistics stage
// and the result buffer still holds the previous frame's results.
// Reset is synchronous; the row store is not cleared and needs no pass.
//
module rgb565_split_region_luma_stats (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pix_valid,
  output logic                               pix_stall,
  input  rgbls_pkg::pix_t                    pix,
  output logic                               res_valid,
  input  logic                               res_stall,
  output rgbls_pkg::res_t                    res,
  input  logic                               cfg_we,
  input  logic [rgbls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbls_pkg::CFG_DAT_W-1:0]    cfg_data
);

  // Widening stage contents.
  typedef struct packed {
    logic [7:0]               r;
    logic [7:0]               g;
    logic [7:0]               b;
    logic [rgbls_pkg::XW-1:0] x;
    logic                     region;
    logic                     h_test;
    logic                     v_test;
    logic                     eof;
    logic                     mismatch;
  } wide_t;

  // Configuration registers and derived values.
  logic [rgbls_pkg::DIM_W-1:0]   frame_width;
  logic [rgbls_pkg::DIM_W-1:0]   frame_height;
  rgbls_pkg::levels_t            levels;
  logic [rgbls_pkg::DIM_W-1:0]   width_eff;
  logic [rgbls_pkg::DIM_W-1:0]   width_eff_next;
  logic [rgbls_pkg::DIM_W-1:0]   height_eff_next;
  logic [rgbls_pkg::XW-1:0]      half;
  logic [rgbls_pkg::SEEN_W-1:0]  expected;

  // Raster position.
  logic [rgbls_pkg::XW-1:0]      column_index;
  logic [rgbls_pkg::ROW_W-1:0]   row_index;
  logic [rgbls_pkg::SEEN_W-1:0]  pixels_seen;
  logic [rgbls_pkg::XW-1:0]      x;
  logic [rgbls_pkg::ROW_W-1:0]   row_eff;
  logic                          row_end;
  logic [rgbls_pkg::XW-1:0]      column_next;
  logic [rgbls_pkg::ROW_W-1:0]   row_next;
  logic [rgbls_pkg::SEEN_W-1:0]  pixels_seen_next;
  wide_t                         wide_next;

  // Pipeline.
  logic                          accept;
  logic                          advance;
  logic                          a_valid;
  wide_t                         a;
  logic                          b_valid;
  rgbls_pkg::px_t                b;
  logic [rgbls_pkg::LUMA_W-1:0]  row_rd;
  logic                          take;
  rgbls_pkg::stats_t [1:0]       totals_final;
  logic                          res_busy;

  assign advance   = !(b_valid && b.eof && res_busy);
  assign pix_stall = !advance;
  assign accept    = pix_valid && advance;
  assign take      = b_valid && advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= rgbls_pkg::WIDTH_RESET;
      frame_height     <= rgbls_pkg::HEIGHT_RESET;
      levels.saturate  <= rgbls_pkg::SATURATE_RESET;
      levels.highlight <= rgbls_pkg::HIGHLIGHT_RESET;
      levels.edge_step <= rgbls_pkg::EDGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgbls_pkg::CFG_FRAME_WIDTH:     frame_width      <= cfg_data;
        rgbls_pkg::CFG_FRAME_HEIGHT:    frame_height     <= cfg_data;
        rgbls_pkg::CFG_SATURATE_LEVEL:  levels.saturate  <= cfg_data[rgbls_pkg::LEVEL_W-1:0];
        rgbls_pkg::CFG_HIGHLIGHT_LEVEL: levels.highlight <= cfg_data[rgbls_pkg::LEVEL_W-1:0];
        rgbls_pkg::CFG_EDGE_STEP:       levels.edge_step <= cfg_data[rgbls_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry, split column and expected pixel count.
  always_comb begin
    if (frame_width < rgbls_pkg::DIM_FLOOR) begin
      width_eff_next = rgbls_pkg::DIM_FLOOR;
    end else if (frame_width > rgbls_pkg::WIDTH_LIMIT) begin
      width_eff_next = rgbls_pkg::WIDTH_LIMIT;
    end else begin
      width_eff_next = frame_width;
    end
    if (frame_height < rgbls_pkg::DIM_FLOOR) begin
      height_eff_next = rgbls_pkg::DIM_FLOOR;
    end else if (frame_height > rgbls_pkg::HEIGHT_LIMIT) begin
      height_eff_next = rgbls_pkg::HEIGHT_LIMIT;
    end else begin
      height_eff_next = frame_height;
    end
  end

  always_ff @(posedge clk) begin
    width_eff <= width_eff_next;
    half      <= width_eff_next[rgbls_pkg::XW:1];
    expected  <= rgbls_pkg::SEEN_W'(width_eff_next * height_eff_next);
  end

  // Position of the arriving pixel and the position after it.
  always_comb begin
    if ({1'b0, column_index} >= width_eff) begin
      x       = '0;
      row_eff = (row_index == rgbls_pkg::ROW_LIMIT) ? row_index : row_index + 1'b1;
    end else begin
      x       = column_index;
      row_eff = row_index;
    end
    row_end = (({1'b0, x} + 1'b1) >= width_eff);
    if (row_end) begin
      column_next = '0;
      row_next    = (row_eff == rgbls_pkg::ROW_LIMIT) ? row_eff : row_eff + 1'b1;
    end else begin
      column_next = x + 1'b1;
      row_next    = row_eff;
    end
    pixels_seen_next = (&pixels_seen) ? pixels_seen : pixels_seen + 1'b1;

    wide_next.r        = rgbls_pkg::expand5(pix.pixel_word[15:11]);
    wide_next.g        = rgbls_pkg::expand6(pix.pixel_word[10:5]);
    wide_next.b        = rgbls_pkg::expand5(pix.pixel_word[4:0]);
    wide_next.x        = x;
    wide_next.region   = (x >= half);
    wide_next.h_test   = (x != '0) && (x != half);
    wide_next.v_test   = (row_eff != '0);
    wide_next.eof      = pix.end_of_frame;
    wide_next.mismatch = (pixels_seen_next != expected);
  end

  // Position state returns to the frame origin after the last pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      pixels_seen  <= '0;
    end else if (accept) begin
      if (pix.end_of_frame) begin
        column_index <= '0;
        row_index    <= '0;
        pixels_seen  <= '0;
      end else begin
        column_index <= column_next;
        row_index    <= row_next;
        pixels_seen  <= pixels_seen_next;
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= accept;
      b_valid <= a_valid;
    end
  end

  // Pipeline payload: widen, then weight into luma.
  always_ff @(posedge clk) begin
    if (advance) begin
      a          <= wide_next;
      b.x        <= a.x;
      b.luma     <= rgbls_pkg::luma_of(a.r, a.g, a.b);
      b.row_luma <= row_rd;
      b.region   <= a.region;
      b.h_test   <= a.h_test;
      b.v_test   <= a.v_test;
      b.eof      <= a.eof;
      b.mismatch <= a.mismatch;
    end
  end

  // Row store: read at acceptance, written back as the pixel leaves.
  rgbls_row_ram u_row_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (x),
    .rd_data (row_rd),
    .wr_en   (take),
    .wr_addr (b.x),
    .wr_data (b.luma)
  );

  // Statistics per half.
  rgbls_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .px           (b),
    .levels       (levels),
    .totals_final (totals_final)
  );

  // Result buffer and output sequencing.
  rgbls_result_buf u_result_buf (
    .clk           (clk),
    .rst           (rst),
    .load          (take && b.eof),
    .load_mismatch (b.mismatch),
    .load_stats    (totals_final),
    .busy          (res_busy),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res           (res)
  );

`ifndef NO_ASSERTIONS
  // A frame's snapshot never overwrites results still being sent.
  assert property (@(posedge clk) disable iff (rst)
    (take && b.eof) |-> !res_busy)
    else $error("result buffer loaded while busy");

  // After the final result of a frame is taken, no further result follows at once.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && res.last) |=> !res_valid)
    else $error("result after last of frame");

  // A mismatch status carries no totals and closes the frame.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status) |-> (res.last && (res.pixel_count == '0)
                                   && (res.luma_sum == '0)))
    else $error("mismatch result carries totals");

  // The input stalls only while a frame end waits in the statistics stage.
  assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (b_valid && b.eof && res_valid))
    else $error("input stalled without pending frame end");
`endif

endmodule
